/* rtl/core/fvl_pkg.sv */
// Shared types and constants for the face velocity wet/dry limiter.
`default_nettype none

package fvl_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_W     = 31;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * REG_W;
    localparam int QUOT_W    = REG_W;
    localparam int DIV_LAT   = QUOT_W + 1;
    // edges from input accept to the edge that takes the result word
    localparam int PIPE_LAT  = DIV_LAT + 5;

    localparam logic [REG_W-1:0] WET_DEPTH_RST = 31'd655;
    localparam logic [REG_W-1:0] CELL_SIZE_RST = 31'd65536;
    localparam logic [REG_W-1:0] TIME_STEP_RST = 31'd65536;

    localparam logic signed [DATA_W-1:0] FLOW_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] FLOW_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CFG_WET_DEPTH   = 2'd0,
        CFG_CELL_WIDTH  = 2'd1,
        CFG_CELL_HEIGHT = 2'd2,
        CFG_TIME_STEP   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] velocity_x;
        logic signed [DATA_W-1:0] velocity_y;
        logic [REG_W-1:0]         face_area_x;
        logic [REG_W-1:0]         face_area_y;
        logic [REG_W-1:0]         depth_here;
        logic [REG_W-1:0]         depth_east;
        logic [REG_W-1:0]         depth_north;
        logic                     limited_here;
        logic                     limited_east;
        logic                     limited_north;
    } t_fvl_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] limited_velocity_x;
        logic signed [DATA_W-1:0] limited_velocity_y;
        logic signed [DATA_W-1:0] flow_x;
        logic signed [DATA_W-1:0] flow_y;
        logic [REG_W-1:0]         courant_x;
        logic [REG_W-1:0]         courant_y;
    } t_fvl_out;

endpackage

`default_nettype wire

/* rtl/core/face_velocity_wet_dry_limiter_top.sv */
// Top level of the face velocity wet/dry limiter pipeline.
// Takes one cell word per clock whenever busy is low (busy is high only for the
// first cycle out of reset) and returns one result word per cell, strobed by
// o_result_valid for one cycle. Pipeline length is set by the two 31-stage
// Courant dividers (one quotient bit per stage) that run beside the limit,
// multiply and flow saturation stages.
// The result port has no back pressure; words come out in input order.
`default_nettype none

module face_velocity_wet_dry_limiter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fvl_pkg::t_fvl_in            i_item,
    output logic                        o_result_valid,
    output fvl_pkg::t_fvl_out           o_result,
    input  logic                        i_cfg_we,
    input  fvl_pkg::t_cfg_idx           i_cfg_index,
    input  logic [fvl_pkg::REG_W-1:0]   i_cfg_wdata
);
    import fvl_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic [REG_W-1:0]         ax;
        logic [REG_W-1:0]         ay;
        logic                     kill_x;
        logic                     kill_y;
        logic                     dry_here;
        logic                     dry_east;
        logic                     dry_north;
    } t_s2;

    typedef struct packed {
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] fx;
        logic signed [DATA_W-1:0] fy;
    } t_dly;

    function automatic logic signed [DATA_W-1:0] sat_flow(
        input logic              neg,
        input logic [PROD_W-1:0] prod
    );
        logic [PROD_W-FRAC_BITS-1:0] m;
        logic                        hi;
        logic [DATA_W-1:0]           f;
        m  = prod[PROD_W-1:FRAC_BITS];
        hi = (m[PROD_W-FRAC_BITS-1:DATA_W] != '0);
        if (neg) begin
            if (hi || (m[DATA_W-1] && (m[DATA_W-2:0] != '0))) begin
                f = FLOW_MIN;
            end else begin
                f = '0 - m[DATA_W-1:0];
            end
        end else begin
            if (hi || m[DATA_W-1]) begin
                f = FLOW_MAX;
            end else begin
                f = m[DATA_W-1:0];
            end
        end
        return f;
    endfunction

    logic [REG_W-1:0]  r_wet_depth;
    logic [REG_W-1:0]  r_cell_width;
    logic [REG_W-1:0]  r_cell_height;
    logic [REG_W-1:0]  r_time_step;
    logic [PROD_W-1:0] r_thr_x;
    logic [PROD_W-1:0] r_thr_y;
    logic              r_busy;

    logic              r_s1_valid;
    t_fvl_in           r_s1;
    logic              r_s2_valid;
    t_s2               r_s2;

    logic              w_zero_x;
    logic              w_zero_y;
    logic [DATA_W-1:0] w_abs_x;
    logic [DATA_W-1:0] w_abs_y;

    logic                     r_s3_valid;
    logic signed [DATA_W-1:0] r_s3_vx;
    logic signed [DATA_W-1:0] r_s3_vy;
    logic [DATA_W-1:0]        r_s3_mag_x;
    logic [DATA_W-1:0]        r_s3_mag_y;
    logic [REG_W-1:0]         r_s3_ax;
    logic [REG_W-1:0]         r_s3_ay;

    logic [PROD_W:0]   w_fp_x;
    logic [PROD_W:0]   w_fp_y;
    logic [PROD_W:0]   w_num_x;
    logic [PROD_W:0]   w_num_y;

    logic                     r_s4_valid;
    logic signed [DATA_W-1:0] r_s4_vx;
    logic signed [DATA_W-1:0] r_s4_vy;
    logic [PROD_W-1:0]        r_s4_fp_x;
    logic [PROD_W-1:0]        r_s4_fp_y;
    logic [PROD_W-1:0]        r_s4_num_x;
    logic [PROD_W-1:0]        r_s4_num_y;

    t_dly               r_dly [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] r_dly_valid;
    logic [REG_W-1:0]   w_cour_x;
    logic [REG_W-1:0]   w_cour_y;

    logic              r_out_valid;
    t_fvl_out          r_out;

    // configuration and wet-area thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_depth   <= WET_DEPTH_RST;
            r_cell_width  <= CELL_SIZE_RST;
            r_cell_height <= CELL_SIZE_RST;
            r_time_step   <= TIME_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WET_DEPTH:   r_wet_depth   <= i_cfg_wdata;
                CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_wdata;
                CFG_CELL_HEIGHT: r_cell_height <= i_cfg_wdata;
                CFG_TIME_STEP:   r_time_step   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_x <= r_wet_depth * r_cell_height;
        r_thr_y <= r_wet_depth * r_cell_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_dly_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= start && !r_busy;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_dly_valid <= {r_dly_valid[DIV_LAT-2:0], r_s4_valid};
            r_out_valid <= r_dly_valid[DIV_LAT-1];
        end
    end

    // stage 1: capture, depth and flag tests
    always_ff @(posedge i_clk) begin
        r_s1 <= i_item;
        r_s2.vx        <= r_s1.velocity_x;
        r_s2.vy        <= r_s1.velocity_y;
        r_s2.ax        <= r_s1.face_area_x;
        r_s2.ay        <= r_s1.face_area_y;
        r_s2.kill_x    <= r_s1.limited_here || r_s1.limited_east;
        r_s2.kill_y    <= r_s1.limited_here || r_s1.limited_north;
        r_s2.dry_here  <= (r_s1.depth_here < r_wet_depth);
        r_s2.dry_east  <= (r_s1.depth_east < r_wet_depth);
        r_s2.dry_north <= (r_s1.depth_north < r_wet_depth);
    end

    // stage 2: wet-area test and limiting
    assign w_zero_x = (PROD_W'({r_s2.ax, {FRAC_BITS{1'b0}}}) < r_thr_x) || r_s2.kill_x
                   || (r_s2.dry_here && !r_s2.vx[DATA_W-1] && (r_s2.vx != '0))
                   || (r_s2.dry_east && r_s2.vx[DATA_W-1]);
    assign w_zero_y = (PROD_W'({r_s2.ay, {FRAC_BITS{1'b0}}}) < r_thr_y) || r_s2.kill_y
                   || (r_s2.dry_here && !r_s2.vy[DATA_W-1] && (r_s2.vy != '0))
                   || (r_s2.dry_north && r_s2.vy[DATA_W-1]);
    assign w_abs_x  = r_s2.vx[DATA_W-1] ? ('0 - r_s2.vx) : r_s2.vx;
    assign w_abs_y  = r_s2.vy[DATA_W-1] ? ('0 - r_s2.vy) : r_s2.vy;

    always_ff @(posedge i_clk) begin
        r_s3_vx    <= w_zero_x ? '0 : r_s2.vx;
        r_s3_vy    <= w_zero_y ? '0 : r_s2.vy;
        r_s3_mag_x <= w_zero_x ? '0 : w_abs_x;
        r_s3_mag_y <= w_zero_y ? '0 : w_abs_y;
        r_s3_ax    <= r_s2.ax;
        r_s3_ay    <= r_s2.ay;
    end

    // stage 3: magnitude products
    assign w_fp_x  = r_s3_mag_x * r_s3_ax;
    assign w_fp_y  = r_s3_mag_y * r_s3_ay;
    assign w_num_x = r_s3_mag_x * r_time_step;
    assign w_num_y = r_s3_mag_y * r_time_step;

    always_ff @(posedge i_clk) begin
        r_s4_vx    <= r_s3_vx;
        r_s4_vy    <= r_s3_vy;
        r_s4_fp_x  <= w_fp_x[PROD_W-1:0];
        r_s4_fp_y  <= w_fp_y[PROD_W-1:0];
        r_s4_num_x <= w_num_x[PROD_W-1:0];
        r_s4_num_y <= w_num_y[PROD_W-1:0];
    end

    // stage 4 on: flow saturation, then delay alongside the dividers
    always_ff @(posedge i_clk) begin
        r_dly[0].vx <= r_s4_vx;
        r_dly[0].vy <= r_s4_vy;
        r_dly[0].fx <= sat_flow(r_s4_vx[DATA_W-1], r_s4_fp_x);
        r_dly[0].fy <= sat_flow(r_s4_vy[DATA_W-1], r_s4_fp_y);
        for (int j = 1; j < DIV_LAT; j++) begin
            r_dly[j] <= r_dly[j-1];
        end
    end

    fvl_cdiv u_cdiv_x (
        .i_clk  (i_clk),
        .i_num  (r_s4_num_x),
        .i_size (r_cell_width),
        .o_quot (w_cour_x)
    );

    fvl_cdiv u_cdiv_y (
        .i_clk  (i_clk),
        .i_num  (r_s4_num_y),
        .i_size (r_cell_height),
        .o_quot (w_cour_y)
    );

    always_ff @(posedge i_clk) begin
        r_out.limited_velocity_x <= r_dly[DIV_LAT-1].vx;
        r_out.limited_velocity_y <= r_dly[DIV_LAT-1].vy;
        r_out.flow_x             <= r_dly[DIV_LAT-1].fx;
        r_out.flow_y             <= r_dly[DIV_LAT-1].fy;
        r_out.courant_x          <= w_cour_x;
        r_out.courant_y          <= w_cour_y;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(PIPE_LAT) o_result_valid)
        else $error("result word missing at fixed latency");

    a_dry_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.limited_velocity_x == '0))
            |-> ((o_result.flow_x == '0) && (o_result.courant_x == '0)))
        else $error("x face zeroed but flow or Courant nonzero");

    a_flow_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.limited_velocity_x[DATA_W-1]
                        && !o_result.limited_velocity_y[DATA_W-1])
            |-> (!o_result.flow_x[DATA_W-1] && !o_result.flow_y[DATA_W-1]))
        else $error("flow sign disagrees with velocity");

endmodule

`default_nettype wire

/* rtl/core/fvl_cdiv.sv */
// Pipelined restoring divider for the Courant number, one quotient bit per stage, saturating.
`default_nettype none

module fvl_cdiv (
    input  logic                        i_clk,
    input  logic [fvl_pkg::PROD_W-1:0]  i_num,
    input  logic [fvl_pkg::REG_W-1:0]   i_size,
    output logic [fvl_pkg::REG_W-1:0]   o_quot
);
    import fvl_pkg::*;

    logic [REG_W-1:0]  r_rem  [0:QUOT_W-1];
    logic [REG_W-1:0]  r_low  [0:QUOT_W-1];
    logic [QUOT_W-1:0] r_q    [0:QUOT_W];
    logic              r_zero [0:QUOT_W];
    logic              r_sat  [0:QUOT_W];

    // zero numerator wins; zero size or quotient of 2^31 and up saturates
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num[PROD_W-1:REG_W];
        r_low[0]  <= i_num[REG_W-1:0];
        r_q[0]    <= '0;
        r_zero[0] <= (i_num == '0);
        r_sat[0]  <= (i_num >= {i_size, {REG_W{1'b0}}});
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic [REG_W:0] w_shift;
        logic [REG_W:0] w_diff;
        logic           w_ge;

        assign w_shift = {r_rem[k], r_low[k][REG_W-1]};
        assign w_diff  = w_shift - {1'b0, i_size};
        assign w_ge    = (w_shift >= {1'b0, i_size});

        always_ff @(posedge i_clk) begin
            r_q[k+1]    <= {r_q[k][QUOT_W-2:0], w_ge};
            r_zero[k+1] <= r_zero[k];
            r_sat[k+1]  <= r_sat[k];
        end

        if (k < QUOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= w_ge ? w_diff[REG_W-1:0] : w_shift[REG_W-1:0];
                r_low[k+1] <= {r_low[k][REG_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_zero[QUOT_W] ? '0 :
                    r_sat[QUOT_W]  ? '1 : r_q[QUOT_W];

endmodule

`default_nettype wire

/* verif/fvl_result_checker.sv */
// Checker for the face velocity limiter: predicts each result word and compares it on arrival.
`timescale 1ns / 100ps

module fvl_result_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  fvl_pkg::t_fvl_in          i_item,
    input  logic                      i_result_valid,
    input  fvl_pkg::t_fvl_out         i_result,
    input  logic                      i_cfg_we,
    input  fvl_pkg::t_cfg_idx         i_cfg_index,
    input  logic [fvl_pkg::REG_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    import fvl_pkg::*;

    logic [REG_W-1:0] wet_depth = WET_DEPTH_RST;
    logic [REG_W-1:0] cell_w    = CELL_SIZE_RST;
    logic [REG_W-1:0] cell_h    = CELL_SIZE_RST;
    logic [REG_W-1:0] t_step    = TIME_STEP_RST;

    t_fvl_out awaited_words[$];
    t_fvl_out want;
    int       mismatches = 0;
    int       pending_n  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    function automatic logic [63:0] mag_of(input logic signed [63:0] vel);
        return (vel < 0) ? -vel : vel;
    endfunction

    function automatic logic signed [63:0] gate_face(
        input logic signed [63:0] vel,
        input logic [63:0]        area,
        input logic [63:0]        across,
        input logic [63:0]        wet,
        input logic [63:0]        d_up,
        input logic [63:0]        d_down,
        input logic               flag_a,
        input logic               flag_b
    );
        if ((area << FRAC_BITS) < wet * across) vel = 0;
        if (d_up < wet && vel > 0) vel = 0;
        if (d_down < wet && vel < 0) vel = 0;
        if (flag_a || flag_b) vel = 0;
        return vel;
    endfunction

    // velocity * area, truncated toward zero, saturated to 32 bits signed
    function automatic logic [DATA_W-1:0] flow_of(input logic signed [63:0] vel,
                                                  input logic [63:0] area);
        logic [63:0] mag;
        logic [63:0] neg;
        mag = (mag_of(vel) * area) >> FRAC_BITS;
        if (vel < 0) begin
            if (mag > 64'h8000_0000) return FLOW_MIN;
            neg = 64'd0 - mag;
            return neg[DATA_W-1:0];
        end
        if (mag > 64'h7FFF_FFFF) return FLOW_MAX;
        return mag[DATA_W-1:0];
    endfunction

    function automatic logic [REG_W-1:0] courant_of(input logic [63:0] mag,
                                                    input logic [63:0] step,
                                                    input logic [63:0] size);
        logic [63:0] num;
        logic [63:0] q;
        num = mag * step;
        if (num == 0) return '0;
        if (size == 0) return '1;
        q = num / size;
        return (q > 64'h7FFF_FFFF) ? '1 : q[REG_W-1:0];
    endfunction

    function automatic t_fvl_out predict_cell(input t_fvl_in c);
        t_fvl_out         r;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        vx = gate_face($signed(c.velocity_x), c.face_area_x, cell_h, wet_depth,
                       c.depth_here, c.depth_east, c.limited_here, c.limited_east);
        vy = gate_face($signed(c.velocity_y), c.face_area_y, cell_w, wet_depth,
                       c.depth_here, c.depth_north, c.limited_here, c.limited_north);
        r.limited_velocity_x = vx[DATA_W-1:0];
        r.limited_velocity_y = vy[DATA_W-1:0];
        r.flow_x             = flow_of(vx, c.face_area_x);
        r.flow_y             = flow_of(vy, c.face_area_y);
        r.courant_x          = courant_of(mag_of(vx), t_step, cell_w);
        r.courant_y          = courant_of(mag_of(vy), t_step, cell_h);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wet_depth = WET_DEPTH_RST;
            cell_w    = CELL_SIZE_RST;
            cell_h    = CELL_SIZE_RST;
            t_step    = TIME_STEP_RST;
        end else begin
            if (i_start && !i_busy) awaited_words.push_back(predict_cell(i_item));
            if (i_result_valid) begin
                if (awaited_words.size() == 0) begin
                    $error("result word with no cell waiting");
                    mismatches++;
                end else begin
                    want = awaited_words.pop_front();
                    check_field("limited_velocity_x", want.limited_velocity_x,
                                i_result.limited_velocity_x);
                    check_field("limited_velocity_y", want.limited_velocity_y,
                                i_result.limited_velocity_y);
                    check_field("flow_x", want.flow_x, i_result.flow_x);
                    check_field("flow_y", want.flow_y, i_result.flow_y);
                    check_field("courant_x", {1'b0, want.courant_x},
                                {1'b0, i_result.courant_x});
                    check_field("courant_y", {1'b0, want.courant_y},
                                {1'b0, i_result.courant_y});
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WET_DEPTH:   wet_depth = i_cfg_wdata;
                    CFG_CELL_WIDTH:  cell_w    = i_cfg_wdata;
                    CFG_CELL_HEIGHT: cell_h    = i_cfg_wdata;
                    CFG_TIME_STEP:   t_step    = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_n = awaited_words.size();
    end

endmodule

/* verif/tb_face_velocity_wet_dry_limiter_top.sv */
// Testbench top for the face velocity limiter: clock, reset, cell and register stimulus, verdict.
`timescale 1ns / 100ps

module tb_face_velocity_wet_dry_limiter_top;
    import fvl_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_CELLS = 130;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    t_fvl_in          cell_word = '0;
    logic             cfg_we    = 1'b0;
    t_cfg_idx         cfg_index = CFG_WET_DEPTH;
    logic [REG_W-1:0] cfg_wdata = '0;
    logic             busy;
    logic             result_valid;
    t_fvl_out         result;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    int               cells_sent  = 0;
    int               settings    = 1;

    // register copies, used only to aim stimulus at the thresholds
    logic [REG_W-1:0] cfg_wet = WET_DEPTH_RST;
    logic [REG_W-1:0] cfg_cw  = CELL_SIZE_RST;
    logic [REG_W-1:0] cfg_ch  = CELL_SIZE_RST;
    logic [REG_W-1:0] cfg_ts  = TIME_STEP_RST;

    face_velocity_wet_dry_limiter_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (cell_word),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    fvl_result_checker result_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (cell_word),
        .i_result_valid (result_valid),
        .i_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_face_velocity_wet_dry_limiter_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cell(input t_fvl_in c);
        cell_word <= c;
        start     <= 1'b1;
        do @(posedge clk); while (busy);
        cells_sent++;
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [REG_W-1:0] wet, input logic [REG_W-1:0] cw,
                            input logic [REG_W-1:0] ch, input logic [REG_W-1:0] ts);
        drain();
        write_reg(CFG_WET_DEPTH, wet);
        write_reg(CFG_CELL_WIDTH, cw);
        write_reg(CFG_CELL_HEIGHT, ch);
        write_reg(CFG_TIME_STEP, ts);
        cfg_we  <= 1'b0;
        cfg_wet = wet;
        cfg_cw  = cw;
        cfg_ch  = ch;
        cfg_ts  = ts;
        settings++;
    endtask

    // values a step or two around a threshold one time in three, else zero, full scale or random
    function automatic logic [REG_W-1:0] near(input logic [63:0] center);
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 64'h7FFF_FFFF;
            2: v = 64'($urandom() & 32'h7FFF_FFFF);
            3: v = 64'($urandom_range(0, 32'h0003_0000));
            default: begin
                v = center + 64'($urandom_range(0, 4));
                v = (v < 2) ? 64'd0 : v - 2;
            end
        endcase
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        return v[REG_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] rand_velocity();
        logic [DATA_W-1:0] m;
        case ($urandom_range(0, 5))
            0: m = $urandom();
            1: m = $urandom_range(0, 32'h0004_0000);
            2: m = $urandom_range(0, 32'h0100_0000);
            3: m = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: m = $urandom_range(0, 1);
            default: m = $urandom_range(0, 32'h0000_0400);
        endcase
        if ($urandom_range(0, 1)) m = -m;
        return m;
    endfunction

    function automatic t_fvl_in rand_cell();
        t_fvl_in     c;
        logic [63:0] wet64;
        wet64           = cfg_wet;
        c.velocity_x    = rand_velocity();
        c.velocity_y    = rand_velocity();
        c.face_area_x   = near((wet64 * cfg_ch + 64'hFFFF) >> FRAC_BITS);
        c.face_area_y   = near((wet64 * cfg_cw + 64'hFFFF) >> FRAC_BITS);
        c.depth_here    = near(wet64);
        c.depth_east    = near(wet64);
        c.depth_north   = near(wet64);
        c.limited_here  = ($urandom_range(0, 7) == 0);
        c.limited_east  = ($urandom_range(0, 7) == 0);
        c.limited_north = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    initial begin
        t_fvl_in base;
        t_fvl_in c;
        bit      idle_on;

        base             = '0;
        base.velocity_x  = 32'sh0001_0000;
        base.velocity_y  = -32'sh0001_0000;
        base.face_area_x = 31'h0001_0000;
        base.face_area_y = 31'h0001_0000;
        base.depth_here  = 31'h0001_0000;
        base.depth_east  = 31'h0001_0000;
        base.depth_north = 31'h0001_0000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed cells at reset register values (wet depth 655, unit sizes)
        send_cell('0);
        send_cell(base);
        c = base;
        c.velocity_x  = 32'sh7FFF_FFFF;
        c.velocity_y  = 32'sh8000_0000;
        c.face_area_x = '1;
        c.face_area_y = '1;
        c.depth_here  = '1;
        c.depth_east  = '1;
        c.depth_north = '1;
        send_cell(c);
        c.velocity_x = 32'sh8000_0000;
        c.velocity_y = 32'sh7FFF_FFFF;
        send_cell(c);
        // face area on either side of the wet threshold
        c = base;
        c.face_area_x = 31'd654;
        c.face_area_y = 31'd655;
        send_cell(c);
        c.face_area_x = 31'd655;
        c.face_area_y = 31'd654;
        send_cell(c);
        // flow out of and into a shallow cell, then the limited flags
        c = base;
        c.velocity_y = 32'sh0001_0000;
        c.depth_here = 31'd654;
        send_cell(c);
        c.velocity_x = -32'sh0001_0000;
        c.velocity_y = -32'sh0001_0000;
        send_cell(c);
        c = base;
        c.velocity_x  = -32'sh0002_0000;
        c.depth_east  = 31'd654;
        c.depth_north = 31'd654;
        send_cell(c);
        c.velocity_x = 32'sh0002_0000;
        c.velocity_y = 32'sh0002_0000;
        send_cell(c);
        c = base;
        c.limited_here = 1'b1;
        send_cell(c);
        c = base;
        c.limited_east = 1'b1;
        send_cell(c);
        c = base;
        c.limited_north = 1'b1;
        send_cell(c);
        // flow truncation toward zero and saturation edges
        c = base;
        c.velocity_x  = -32'sd1;
        c.face_area_x = 31'd700;
        c.velocity_y  = -32'sd3;
        c.face_area_y = 31'h0000_8000;
        send_cell(c);
        c = base;
        c.velocity_x  = 32'sh8000_0000;
        c.face_area_x = 31'h0001_0000;
        c.velocity_y  = 32'sh7FFF_FFFF;
        c.face_area_y = 31'h0001_0001;
        send_cell(c);
        c = base;
        c.velocity_x = 32'sd1;
        c.velocity_y = -32'sd1;
        send_cell(c);
        c.face_area_x   = '1;
        c.face_area_y   = '1;
        c.depth_here    = '1;
        c.depth_east    = '1;
        c.depth_north   = '1;
        c.limited_here  = 1'b1;
        c.limited_east  = 1'b1;
        c.limited_north = 1'b1;
        send_cell(c);

        for (int p = 1; p <= 8; p++) begin
            case (p)
                2: set_regs('0, 31'd1, 31'd1, '1);
                3: set_regs('1, '1, '1, '0);
                4: set_regs(REG_W'($urandom_range(0, 32'h0002_0000)), '0, '0,
                            REG_W'($urandom_range(0, 32'h0004_0000)));
                6: set_regs(REG_W'($urandom()), REG_W'($urandom()),
                            REG_W'($urandom()), REG_W'($urandom()));
                5, 7, 8: set_regs(REG_W'($urandom_range(0, 32'h0002_0000)),
                                  REG_W'($urandom_range(1, 32'h0008_0000)),
                                  REG_W'($urandom_range(1, 32'h0008_0000)),
                                  REG_W'($urandom_range(0, 32'h0004_0000)));
                default: ;
            endcase
            idle_on = (p != 8);
            for (int k = 0; k < PHASE_CELLS; k++) begin
                if (p != 8) begin
                    if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
                    if (idle_on && $urandom_range(0, 2) == 0) pause($urandom_range(1, 15));
                end
                send_cell(rand_cell());
            end
        end

        drain();
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("covered %0d cells under %0d register settings, incl. zero cell size,",
                 cells_sent, settings);
        $display("full-scale registers, wet/dry thresholds and saturating flows");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_face_velocity_wet_dry_limiter_top OK");
        end else begin
            $display("tb_face_velocity_wet_dry_limiter_top NOT OK");
        end
        $finish;
    end

endmodule

/* face_velocity_wet_dry_limiter_top.f */
rtl/core/fvl_pkg.sv
rtl/core/fvl_cdiv.sv
rtl/core/face_velocity_wet_dry_limiter_top.sv
verif/fvl_result_checker.sv
verif/tb_face_velocity_wet_dry_limiter_top.sv
